>>> src/tcf_pkg.sv
// ---------------------------------------------------------------------------
// tcf_pkg: shared types and constants of the connection-tracking firewall
// Payload structs, outcome and phase codes, register indexes, table size.
// ---------------------------------------------------------------------------
package tcf_pkg;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [31:0] DEFAULT_PREFIX = 32'h0a000000;
	localparam logic [31:0] DEFAULT_PREFIX_MASK = 32'hff000000;

	// Number of sets in the flow table. The set index is taken as the low bits
	// of the key fold, so this stays a power of two.
	localparam int TABLE_SETS = 1024;

	localparam logic [0:0] REG_PREFIX = 1'b0;
	localparam logic [0:0] REG_PREFIX_MASK = 1'b1;

	localparam logic [2:0] OUT_UNTRACKED = 3'd0;
	localparam logic [2:0] OUT_RESET = 3'd1;
	localparam logic [2:0] OUT_FIN = 3'd2;
	localparam logic [2:0] OUT_ESTAB = 3'd3;
	localparam logic [2:0] OUT_REFRESH = 3'd4;
	localparam logic [2:0] OUT_NEW = 3'd5;
	localparam logic [2:0] OUT_DROP = 3'd6;

	localparam logic [1:0] PH_NONE = 2'd0;
	localparam logic [1:0] PH_SYN = 2'd1;
	localparam logic [1:0] PH_ESTAB = 2'd2;
	localparam logic [1:0] PH_CLOSE = 2'd3;

	typedef struct packed {
		logic        header_ok;
		logic [7:0]  protocol;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic        flag_syn;
		logic        flag_ack;
		logic        flag_fin;
		logic        flag_rst;
		logic [63:0] arrival_time;
	} pkt_in_t;

	typedef struct packed {
		logic       verdict;
		logic [2:0] outcome;
		logic [1:0] flow_phase;
	} pkt_out_t;

endpackage

>>> src/tcf_key_unit.sv
// ---------------------------------------------------------------------------
// tcf_key_unit: canonical key and set index
// Registers the canonical endpoint order, the port pair and the set index.
// ---------------------------------------------------------------------------
module tcf_key_unit
	import tcf_pkg::*;
#(
	parameter int SET_W = 10
) (
	input  logic              clk,
	input  logic              load,
	input  pkt_in_t           pkt,
	output logic [31:0]       lo_q,
	output logic [31:0]       hi_q,
	output logic [31:0]       pp_q,
	output logic [SET_W-1:0]  set_q
);
	logic [47:0] ea, eb;
	logic [31:0] lo, hi, pp, x;
	logic [15:0] fold;

	always_comb begin
		ea = {pkt.source_address, pkt.source_port};
		eb = {pkt.dest_address, pkt.dest_port};
		if (ea <= eb) begin
			lo = pkt.source_address;
			hi = pkt.dest_address;
			pp = {pkt.source_port, pkt.dest_port};
		end else begin
			lo = pkt.dest_address;
			hi = pkt.source_address;
			pp = {pkt.dest_port, pkt.source_port};
		end
		x = lo ^ hi ^ pp;
		fold = x[31:16] ^ x[15:0];
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lo_q <= lo;
			hi_q <= hi;
			pp_q <= pp;
			set_q <= SET_W'(32'(fold) % 32'(1 << SET_W));
		end
	end
endmodule

>>> src/tcp_connection_tracking_firewall_core.sv
// ---------------------------------------------------------------------------
// tcp_connection_tracking_firewall_core: stateful TCP firewall
// Untracked packets present their result in the cycle after the transfer;
// dropped tracked packets pass through the key, probe and decide states, and
// admitted ones through key, probe, decide, a write-back of each way in turn
// and the result state. One packet at a time; the next input transfer may
// follow as soon as the result register is free. Reset clears the phase and
// rank stores with a sweep over every entry, during which no packet is taken.
// ---------------------------------------------------------------------------
module tcp_connection_tracking_firewall_core
	import tcf_pkg::*;
#(
	parameter int TABLE_WAYS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  pkt_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output pkt_out_t    out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	// The set index is the 16-bit fold modulo TABLE_SETS; sets are a power of
	// two here so the index is the low bits of the fold.
	localparam int SET_W = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
	localparam int WAY_W = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
	localparam int ENT_W = SET_W + WAY_W;
	localparam int ENTRIES = 1 << ENT_W;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_KEY, ST_PROBE, ST_DECIDE, ST_WRITE, ST_OUT
	} state_t;

	state_t state_q;
	logic [31:0] prefix_q, mask_q;
	pkt_in_t pkt_q;
	logic outbound_q;

	// Entry stores, one memory each. Key and time stores need no clearing.
	logic [31:0] mem_lo [ENTRIES];
	logic [31:0] mem_hi [ENTRIES];
	logic [31:0] mem_pp [ENTRIES];
	logic [1:0]  mem_ph [ENTRIES];
	logic [63:0] mem_ts [ENTRIES];
	logic [WAY_W-1:0] mem_rk [ENTRIES];

	logic [31:0] lo_q, hi_q, pp_q;
	logic [SET_W-1:0] set_q;
	logic [ENT_W:0] clr_q;

	// Per-way copy of the set, gathered during the probe.
	logic [1:0]       ph_q [TABLE_WAYS];
	logic [WAY_W-1:0] rk_q [TABLE_WAYS];
	logic             mt_q [TABLE_WAYS];
	logic [WAY_W:0]   rd_way_q;   // way whose read address is issued now
	logic [WAY_W:0]   wr_way_q;   // way being written back
	logic             rd_vld_q;
	logic [WAY_W-1:0] tgt_q;
	logic [WAY_W-1:0] old_rk_q;
	logic             promote_q, touch_q, writekey_q;
	logic [1:0]       new_ph_q;

	logic [31:0] rd_lo, rd_hi, rd_pp;
	logic [1:0]  rd_ph;
	logic [WAY_W-1:0] rd_rk;

	tcf_key_unit #(.SET_W(SET_W)) u_key (
		.clk(clk), .load(state_q == ST_KEY), .pkt(pkt_q),
		.lo_q(lo_q), .hi_q(hi_q), .pp_q(pp_q), .set_q(set_q)
	);

	logic [ENT_W-1:0] rd_addr;
	assign rd_addr = {set_q, rd_way_q[WAY_W-1:0]};

	always_ff @(posedge clk) begin
		rd_lo <= mem_lo[rd_addr];
		rd_hi <= mem_hi[rd_addr];
		rd_pp <= mem_pp[rd_addr];
		rd_ph <= mem_ph[rd_addr];
		rd_rk <= mem_rk[rd_addr];
	end

	// Decide which way to act on from the gathered set copy.
	logic hit;
	logic [WAY_W-1:0] hit_w, empty_w, lru_w;
	logic have_empty, have_lru;
	always_comb begin
		hit = 1'b0; hit_w = '0; have_empty = 1'b0; empty_w = '0;
		have_lru = 1'b0; lru_w = '0;
		for (int w = TABLE_WAYS - 1; w >= 0; w--) begin
			if (mt_q[w]) begin hit = 1'b1; hit_w = WAY_W'(w); end
			if (ph_q[w] == PH_NONE) begin have_empty = 1'b1; empty_w = WAY_W'(w); end
			if (rk_q[w] == WAY_W'(TABLE_WAYS - 1)) begin
				have_lru = 1'b1; lru_w = WAY_W'(w);
			end
		end
	end

	// Write-back address and rank update of the current way.
	logic [WAY_W-1:0] wr_w, new_rk;
	assign wr_w = wr_way_q[WAY_W-1:0];
	always_comb begin
		new_rk = rk_q[wr_w];
		if (wr_w == tgt_q) new_rk = promote_q ? '0 : WAY_W'(TABLE_WAYS - 1);
		else if (promote_q && rk_q[wr_w] < old_rk_q) new_rk = rk_q[wr_w] + 1'b1;
		else if (!promote_q && rk_q[wr_w] > old_rk_q) new_rk = rk_q[wr_w] - 1'b1;
	end

	// Memory writes: clearing sweep, then one way per cycle of write-back.
	logic [ENT_W-1:0] clr_addr;
	assign clr_addr = clr_q[ENT_W-1:0];
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			mem_ph[clr_addr] <= PH_NONE;
			mem_rk[clr_addr] <= clr_addr[WAY_W-1:0];
		end else if (state_q == ST_WRITE) begin
			mem_rk[{set_q, wr_w}] <= new_rk;
			if (wr_w == tgt_q) begin
				mem_ph[{set_q, wr_w}] <= new_ph_q;
				if (touch_q) mem_ts[{set_q, wr_w}] <= pkt_q.arrival_time;
				if (writekey_q) begin
					mem_lo[{set_q, wr_w}] <= lo_q;
					mem_hi[{set_q, wr_w}] <= hi_q;
					mem_pp[{set_q, wr_w}] <= pp_q;
				end
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE) && !out_valid;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			prefix_q <= DEFAULT_PREFIX;
			mask_q <= DEFAULT_PREFIX_MASK;
			out_valid <= 1'b0;
			rd_way_q <= '0;
			wr_way_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_PREFIX) prefix_q <= cfg_data;
				else mask_q <= cfg_data;
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (ENT_W + 1)'(ENTRIES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						pkt_q <= in_data;
						outbound_q <= (in_data.source_address & mask_q) == prefix_q;
						if (!in_data.header_ok || in_data.protocol != PROTO_TCP) begin
							out_data <= '{verdict: 1'b0, outcome: OUT_UNTRACKED,
								flow_phase: PH_NONE};
							out_valid <= 1'b1;
						end else begin
							state_q <= ST_KEY;
						end
					end
				end
				ST_KEY: begin
					rd_way_q <= '0;
					rd_vld_q <= 1'b0;
					state_q <= ST_PROBE;
				end
				ST_PROBE: begin
					// Address issued one cycle, data gathered the next.
					if (rd_vld_q) begin
						ph_q[rd_way_q[WAY_W-1:0] - 1'b1] <= rd_ph;
						rk_q[rd_way_q[WAY_W-1:0] - 1'b1] <= rd_rk;
						mt_q[rd_way_q[WAY_W-1:0] - 1'b1] <= (rd_ph != PH_NONE) &&
							rd_lo == lo_q && rd_hi == hi_q && rd_pp == pp_q;
					end
					if (rd_way_q == (WAY_W + 1)'(TABLE_WAYS)) state_q <= ST_DECIDE;
					rd_way_q <= rd_way_q + 1'b1;
					rd_vld_q <= 1'b1;
				end
				ST_DECIDE: begin
					wr_way_q <= '0;
					state_q <= ST_WRITE;
					writekey_q <= 1'b0;
					touch_q <= 1'b1;
					promote_q <= 1'b1;
					if (hit) begin
						tgt_q <= hit_w;
						old_rk_q <= rk_q[hit_w];
						out_data.verdict <= 1'b0;
						if (pkt_q.flag_rst) begin
							promote_q <= 1'b0; touch_q <= 1'b0;
							new_ph_q <= PH_NONE;
							out_data.outcome <= OUT_RESET;
							out_data.flow_phase <= PH_NONE;
						end else if (pkt_q.flag_fin) begin
							new_ph_q <= PH_CLOSE;
							out_data.outcome <= OUT_FIN;
							out_data.flow_phase <= PH_CLOSE;
						end else if (ph_q[hit_w] == PH_SYN && pkt_q.flag_syn &&
								pkt_q.flag_ack && !outbound_q) begin
							new_ph_q <= PH_ESTAB;
							out_data.outcome <= OUT_ESTAB;
							out_data.flow_phase <= PH_ESTAB;
						end else begin
							new_ph_q <= ph_q[hit_w];
							out_data.outcome <= OUT_REFRESH;
							out_data.flow_phase <= ph_q[hit_w];
						end
					end else if (pkt_q.flag_syn && !pkt_q.flag_ack && outbound_q) begin
						tgt_q <= have_empty ? empty_w : (have_lru ? lru_w : '0);
						old_rk_q <= rk_q[have_empty ? empty_w : (have_lru ? lru_w : '0)];
						writekey_q <= 1'b1;
						new_ph_q <= PH_SYN;
						out_data <= '{verdict: 1'b0, outcome: OUT_NEW, flow_phase: PH_SYN};
					end else begin
						out_data <= '{verdict: 1'b1, outcome: OUT_DROP, flow_phase: PH_NONE};
						out_valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_WRITE: begin
					wr_way_q <= wr_way_q + 1'b1;
					if (wr_way_q == (WAY_W + 1)'(TABLE_WAYS - 1)) state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A packet is only taken while no result is waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !out_valid)
		else $error("input transfer while result pending");
	// The probe never runs past the last way.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (rd_way_q <= (WAY_W + 1)'(TABLE_WAYS)))
		else $error("probe past last way");
	// A result appears only after idle, decide or the result state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_IDLE || $past(state_q) == ST_DECIDE
			|| $past(state_q) == ST_OUT))
		else $error("unexpected result source");
endmodule
